@@ rtl/bfp_pkg.sv @@
// bfp_pkg: beat types, status codes and helpers for the bit field packer.
// No dependencies; imported by every module of the packer.
`default_nettype none

package bfp_pkg;

    localparam int unsigned ValueW   = 64;
    localparam int unsigned WidthW   = 7;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned StreamW  = ValueW + ByteW;
    localparam int unsigned CountW   = 4;
    localparam int unsigned PendW    = 3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_WIDTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_ORDER = 2'd2;

    typedef struct packed {
        logic [ValueW-1:0] field_value;
        logic [WidthW-1:0] field_width;
        logic              little_endian;
        logic              end_of_message;
    } in_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             last_byte;
        logic [1:0]       status;
    } out_t;

    typedef struct packed {
        logic [StreamW-1:0] stream;
        logic [CountW-1:0]  count;
        logic               eom;
        logic [1:0]         status;
    } work_t;

    function automatic logic [ValueW-1:0] byte_reverse(input logic [ValueW-1:0] v);
        logic [ValueW-1:0] r;
        r = '0;
        for (int i = 0; i < ValueW / ByteW; i++) begin
            r[ValueW-1-ByteW*i -: ByteW] = v[ByteW*i +: ByteW];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bit_field_packer.sv @@
// bit_field_packer: top level; packs 1 to 64 bit fields into bytes, big or little endian.
// Instantiates bfp_front and bfp_emit. Depends on bfp_pkg.
//
//   channel  | direction | beat payload                                   | handshake
//   s_       | in        | field_value, field_width, little_endian, eom   | s_valid/s_ready
//   m_       | out       | out_byte, last_byte, status                    | m_valid/m_ready
//
// A field is aligned behind the pending bits in the cycle it is taken; its
// bytes then leave one per cycle while m_ready allows; s_ready stays low until
// the last one moves to the output register. A field that completes no byte
// leaves s_ready high, and an error beat sends one byte with its status. The
// byte shifter is the rate limit. Reset is synchronous and empties the partial
// byte. A stall on m_ready holds the output register and the shifter.
`default_nettype none

module bit_field_packer import bfp_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    work_t work;
    logic  accept;

    assign accept = s_valid && s_ready;

    bfp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .accept  (accept),
        .work    (work)
    );

    bfp_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .work    (work),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/bfp_front.sv @@
// bfp_front: input stage of the packer; aligns one field behind the pending bits.
// Holds the partial byte between beats. Depends on bfp_pkg.
`default_nettype none

module bfp_front import bfp_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire in_t   s_data,
    input  wire logic  accept,
    output work_t      work
);

    logic [ByteW-1:0]   pend_bits_reg, pend_bits_next;
    logic [PendW-1:0]   pend_cnt_reg, pend_cnt_next;

    logic               bad_width;
    logic               bad_order;
    logic [WidthW-1:0]  align_shift;
    logic [ValueW-1:0]  aligned;
    logic [ValueW-1:0]  keep_mask;
    logic [ValueW-1:0]  field_bits;
    logic [3:0]         pad_shift;
    logic [ByteW-1:0]   head_byte;
    logic [StreamW-1:0] stream;
    logic [WidthW-1:0]  total;
    logic [3:0]         full_bytes;
    logic [2:0]         rem_bits;
    logic [StreamW-1:0] tail;
    logic [3:0]         rem_shift;

    always_comb begin
        bad_width  = (s_data.field_width == '0) || (s_data.field_width > WidthW'(ValueW));
        bad_order  = s_data.little_endian && (s_data.field_width[2:0] != 3'd0);
        align_shift = WidthW'(ValueW) - s_data.field_width;
        aligned    = s_data.little_endian ? byte_reverse(s_data.field_value)
                                          : (s_data.field_value << align_shift[5:0]);
        keep_mask  = ~({ValueW{1'b1}} >> s_data.field_width);
        field_bits = aligned & keep_mask;

        pad_shift  = 4'd8 - {1'b0, pend_cnt_reg};
        head_byte  = pend_bits_reg << pad_shift;
        stream     = {head_byte, {ValueW{1'b0}}} | ({field_bits, {ByteW{1'b0}}} >> pend_cnt_reg);

        total      = {{(WidthW-PendW){1'b0}}, pend_cnt_reg} + s_data.field_width;
        full_bytes = total[6:3];
        rem_bits   = total[2:0];
        tail       = stream << {full_bytes, 3'b000};
        rem_shift  = 4'd8 - {1'b0, rem_bits};

        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;

        if (bad_width || bad_order) begin
            work.stream = '0;
            work.count  = CountW'(1);
            work.eom    = 1'b0;
            work.status = bad_width ? STATUS_BAD_WIDTH : STATUS_BAD_ORDER;
        end else begin
            work.stream = stream;
            work.count  = full_bytes
                        + CountW'(s_data.end_of_message && (rem_bits != 3'd0));
            work.eom    = s_data.end_of_message;
            work.status = STATUS_OK;
            if (s_data.end_of_message) begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end else begin
                pend_bits_next = tail[StreamW-1 -: ByteW] >> rem_shift;
                pend_cnt_next  = rem_bits;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else if (accept) begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bfp_emit.sv @@
// bfp_emit: byte shifter and output register of the packer.
// Sends the aligned stream one byte per beat. Depends on bfp_pkg.
`default_nettype none

module bfp_emit import bfp_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire work_t work,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_t       m_data
);

    logic [StreamW-1:0] stream_reg, stream_next;
    logic [CountW-1:0]  left_reg, left_next;
    logic               eom_reg, eom_next;
    logic [1:0]         status_reg, status_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    logic out_free;
    logic pop;
    logic load;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        pop      = (left_reg != '0) && out_free;
        s_ready  = (left_reg == '0) || ((left_reg == CountW'(1)) && out_free);
        load     = s_valid && s_ready;

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (pop) begin
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = stream_reg[StreamW-1 -: ByteW];
            m_data_next.last_byte = eom_reg && (left_reg == CountW'(1));
            m_data_next.status    = status_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        stream_next = stream_reg;
        left_next   = left_reg;
        eom_next    = eom_reg;
        status_next = status_reg;
        if (load) begin
            stream_next = work.stream;
            left_next   = work.count;
            eom_next    = work.eom;
            status_next = work.status;
        end else if (pop) begin
            stream_next = stream_reg << ByteW;
            left_next   = left_reg - CountW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stream_reg <= stream_next;
        eom_reg    <= eom_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
